[design/patf_pkg.sv]
// ----------------------------------------------------------------------------
// Phase-angle triac firing package
// Opcodes, reset values and the scaled reciprocal table for the delay divide.
// ----------------------------------------------------------------------------
package patf_pkg;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ZERO_CROSS = 2'd1,
        OP_SET_LEVEL  = 2'd2,
        OP_SET_ENABLE = 2'd3
    } t_opcode;

    localparam logic [6:0]  LEVEL_FULL        = 7'd100;
    localparam logic [6:0]  LEVEL_MIN_FIRE    = 7'd2;
    localparam logic [15:0] DELAY_MARGIN      = 16'd100;
    localparam logic [15:0] DELAY_RESET       = 16'd9999;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd8333;

    // floor(level * H / 100) equals (H * level * RECIP) >> RECIP_SHIFT for every
    // product level * H below 2^23, which covers all 16-bit H and levels up to 99.
    localparam int          RECIP_SHIFT = 30;
    localparam int          RECIP_W     = 30;
    localparam longint      RECIP       = 64'd10737419;
    localparam int          PROD_W      = RECIP_W + 16;

    typedef logic [RECIP_W-1:0] t_recip_table [128];

    function automatic t_recip_table build_recip_table();
        t_recip_table t;
        for (int i = 0; i < 128; i++) begin
            if (i < 100) begin
                t[i] = RECIP_W'(longint'(i) * RECIP);
            end else begin
                t[i] = '0;
            end
        end
        return t;
    endfunction

    localparam t_recip_table RECIP_TABLE = build_recip_table();

endpackage

[design/phase_angle_triac_firing_core.sv]
// ----------------------------------------------------------------------------
// Phase-angle triac firing core
// Multi-channel phase-angle controller: per-channel level, firing delay and
// one-shot countdown driven by zero-crossing and tick requests.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ---------------------------------
//  in       input      i_in_valid / o_in_stall    i_opcode i_channel i_level i_enable
//  out      output     o_out_valid / i_out_stall  o_gate_outputs o_triggered_flags
//                                                 o_fired_now
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (half period in ticks)
//
// The core accepts one request per clock while o_in_stall is low. A request is
// captured in the input register and applied to the channel state on the way
// into the output register, which then holds its result until it is taken.
// The longest combinational path is set by the set-level delay: one table
// lookup, one 16 x 30 multiply and a subtract.
// Reset (synchronous, active low) restores the half period to 8333, all levels
// to zero, all delays to 9999, all channels enabled and all masks cleared.
// When the output is stalled the input register still takes one more request;
// only then is o_in_stall raised.
// ----------------------------------------------------------------------------
module phase_angle_triac_firing_core
    import patf_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_level,
    input  logic        i_enable,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_gate_outputs,
    output logic [3:0]  o_triggered_flags,
    output logic [3:0]  o_fired_now,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // The result masks are four bits wide; narrower channel counts are padded
    // with zeros, wider ones report only the first four channels.
    localparam int PAD_W = (CHANNELS > 4) ? CHANNELS : 4;

    // Configuration register.
    logic [15:0]         r_half_period;

    // Input register.
    logic                r_in_valid;
    t_opcode             r_opcode;
    logic [1:0]          r_channel;
    logic [7:0]          r_level_in;
    logic                r_enable_in;

    // Channel state.
    logic [6:0]          r_level     [CHANNELS];
    logic [15:0]         r_delay     [CHANNELS];
    logic [15:0]         r_countdown [CHANNELS];
    logic [CHANNELS-1:0] r_armed;
    logic [CHANNELS-1:0] r_enabled;
    logic [CHANNELS-1:0] r_gate;
    logic [CHANNELS-1:0] r_fired;

    logic [6:0]          n_level     [CHANNELS];
    logic [15:0]         n_delay     [CHANNELS];
    logic [15:0]         n_countdown [CHANNELS];
    logic [CHANNELS-1:0] n_armed;
    logic [CHANNELS-1:0] n_enabled;
    logic [CHANNELS-1:0] n_gate;
    logic [CHANNELS-1:0] n_fired;
    logic [CHANNELS-1:0] n_now;

    // Output register.
    logic                r_out_valid;
    logic [3:0]          r_gate_out;
    logic [3:0]          r_fired_out;
    logic [3:0]          r_now_out;

    logic [PAD_W-1:0]    w_gate_pad;
    logic [PAD_W-1:0]    w_fired_pad;
    logic [PAD_W-1:0]    w_now_pad;

    // Handshake. A request advances from the input register whenever the
    // output register is empty or is being emptied in this cycle.
    logic                w_advance;
    logic                w_in_accept;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Set-level delay computation: clamp the level, then
    // delay = H - floor(level * H / 100) via the reciprocal table, never 0 for a partial level.
    logic [6:0]          w_level_clamped;
    logic [RECIP_W-1:0]  w_recip;
    logic [PROD_W-1:0]   w_product;
    logic [15:0]         w_quotient;
    logic [15:0]         w_diff;
    logic [15:0]         w_delay_new;

    always_comb begin
        if (r_level_in > 8'(LEVEL_FULL)) begin
            w_level_clamped = LEVEL_FULL;
        end else if (r_level_in == 8'd1) begin
            w_level_clamped = LEVEL_MIN_FIRE;
        end else begin
            w_level_clamped = r_level_in[6:0];
        end

        w_recip    = RECIP_TABLE[w_level_clamped];
        w_product  = {{RECIP_W{1'b0}}, r_half_period} * {16'd0, w_recip};
        w_quotient = w_product[PROD_W-1:RECIP_SHIFT];
        w_diff     = r_half_period - w_quotient;

        if (w_level_clamped == 7'd0) begin
            w_delay_new = r_half_period;
        end else if (w_level_clamped == LEVEL_FULL) begin
            w_delay_new = 16'd0;
        end else if (w_diff >= r_half_period) begin
            // The product rounded to nothing: back off by the margin, or fire
            // on the first tick when the half period is too short for that.
            w_delay_new = (r_half_period > DELAY_MARGIN) ?
                          (r_half_period - DELAY_MARGIN) : 16'd1;
        end else if (w_diff == 16'd0) begin
            w_delay_new = 16'd1;
        end else begin
            w_delay_new = w_diff;
        end
    end

    // Next channel state for the request leaving the input register.
    always_comb begin
        n_level     = r_level;
        n_delay     = r_delay;
        n_countdown = r_countdown;
        n_armed     = r_armed;
        n_enabled   = r_enabled;
        n_gate      = r_gate;
        n_fired     = r_fired;
        n_now       = '0;

        case (r_opcode)
            OP_TICK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_armed[i]) begin
                        if (r_countdown[i] <= 16'd1) begin
                            n_countdown[i] = 16'd0;
                            n_armed[i]     = 1'b0;
                            n_fired[i]     = 1'b1;
                            n_now[i]       = 1'b1;
                            if (r_enabled[i]) begin
                                n_gate[i] = 1'b1;
                            end
                        end else begin
                            n_countdown[i] = r_countdown[i] - 16'd1;
                        end
                    end
                end
            end
            OP_ZERO_CROSS: begin
                n_gate  = '0;
                n_fired = '0;
                // Channels at zero keep whatever countdown is still running.
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_level[i] != 7'd0) begin
                        if (r_level[i] < LEVEL_FULL) begin
                            n_countdown[i] = r_delay[i];
                            n_armed[i]     = 1'b1;
                        end else if (r_enabled[i]) begin
                            n_gate[i] = 1'b1;
                        end
                    end
                end
            end
            OP_SET_LEVEL: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(r_channel) == i) begin
                        n_level[i] = w_level_clamped;
                        n_delay[i] = w_delay_new;
                    end
                end
            end
            OP_SET_ENABLE: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(r_channel) == i) begin
                        n_enabled[i] = r_enable_in;
                    end
                end
            end
            default: begin
                n_now = '0;
            end
        endcase
    end

    assign w_gate_pad  = PAD_W'(n_gate);
    assign w_fired_pad = PAD_W'(n_fired);
    assign w_now_pad   = PAD_W'(n_now);

    // Configuration, input register and output control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_half_period <= i_cfg_data;
            end
            r_in_valid  <= w_in_accept || (r_in_valid && !w_advance);
            r_out_valid <= w_advance || (r_out_valid && i_out_stall);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_opcode    <= t_opcode'(i_opcode);
            r_channel   <= i_channel;
            r_level_in  <= i_level;
            r_enable_in <= i_enable;
        end
        if (w_advance) begin
            r_gate_out  <= w_gate_pad[3:0];
            r_fired_out <= w_fired_pad[3:0];
            r_now_out   <= w_now_pad[3:0];
        end
    end

    // Channel state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_level[i]     <= 7'd0;
                r_delay[i]     <= DELAY_RESET;
                r_countdown[i] <= 16'd0;
            end
            r_armed   <= '0;
            r_enabled <= '1;
            r_gate    <= '0;
            r_fired   <= '0;
        end else if (w_advance) begin
            r_level     <= n_level;
            r_delay     <= n_delay;
            r_countdown <= n_countdown;
            r_armed     <= n_armed;
            r_enabled   <= n_enabled;
            r_gate      <= n_gate;
            r_fired     <= n_fired;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_gate_outputs    = r_gate_out;
    assign o_triggered_flags = r_fired_out;
    assign o_fired_now       = r_now_out;

    // A channel can only fire out of an armed countdown.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> ((n_now & ~r_armed) == '0))
        else $error("channel fired without an armed countdown");

    // Firing disarms and a zero crossing clears the flags before arming.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed & r_fired) == '0)
        else $error("channel both armed and triggered");

    // The input side only stalls with both registers occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free register");

    // A request leaving the input register always lands in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced request lost");

endmodule
